/* hdl/cdu_pkg.sv */
// shared types, constants and table functions for the civil date unit
package cdu_pkg;

   typedef enum logic [1:0] {
      ACT_TO_DAYS  = 2'd0,
      ACT_TO_CIVIL = 2'd1,
      ACT_ADD      = 2'd2,
      ACT_DIFF     = 2'd3
   } action_type;

   // register stages inside each conversion path
   localparam int PIPE_DEPTH = 5;

   localparam logic [17:0] ERA_DAYS = 18'd146097;

   typedef struct packed {
      logic signed [16:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [2:0]         weekday;
   } civil_type;

   // first day of each march-based month within the year
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] start_day;
      case (mp)
         4'd0:    start_day = 9'd0;
         4'd1:    start_day = 9'd31;
         4'd2:    start_day = 9'd61;
         4'd3:    start_day = 9'd92;
         4'd4:    start_day = 9'd122;
         4'd5:    start_day = 9'd153;
         4'd6:    start_day = 9'd184;
         4'd7:    start_day = 9'd214;
         4'd8:    start_day = 9'd245;
         4'd9:    start_day = 9'd275;
         4'd10:   start_day = 9'd306;
         4'd11:   start_day = 9'd337;
         4'd12:   start_day = 9'd367;
         default: start_day = 9'd0;
      endcase
      return start_day;
   endfunction

   // floor(yoe / 100) for a year of era 0..399
   function automatic logic [1:0] hundreds(input logic [8:0] yoe);
      logic [1:0] count;
      count = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
      return count;
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         default: len = 5'd30;
      endcase
      return len;
   endfunction

endpackage

/* hdl/cdu_to_days.sv */
// civil date to day number pipeline with leap and validity flags
module cdu_to_days import cdu_pkg::*; (
   input  logic               clock,
   input  logic signed [15:0] year_in,
   input  logic [3:0]         month_in,
   input  logic [4:0]         day_in,
   output logic signed [25:0] days,
   output logic               is_leap,
   output logic               is_valid
);

   localparam logic signed [17:0] YEAR_BIAS  = 18'sd32800;
   localparam logic [12:0]        RECIP_25   = 13'd5243;
   localparam logic [26:0]        EPOCH_BIAS = 27'd12699422;

   // stage 1
   logic               early;
   logic signed [17:0] y_wide;
   logic signed [17:0] yy_wide;
   logic signed [17:0] u_sum;
   logic signed [17:0] uy_sum;
   logic [16:0]        u_in;
   logic [16:0]        uy_in;
   logic [25:0]        q_prod;
   logic [25:0]        qy_prod;
   logic [3:0]         mp_in;

   logic [16:0] s1_u_ff, s1_uy_ff;
   logic [7:0]  s1_q_ff, s1_qy_ff;
   logic [3:0]  s1_mp_ff, s1_month_ff;
   logic [4:0]  s1_day_ff;

   always_comb begin
      early   = month_in <= 4'd2;
      y_wide  = {{2{year_in[15]}}, year_in};
      yy_wide = y_wide - {17'd0, early};
      u_sum   = yy_wide + YEAR_BIAS;
      uy_sum  = y_wide + YEAR_BIAS;
      u_in    = u_sum[16:0];
      uy_in   = uy_sum[16:0];
      q_prod  = {13'd0, u_in[16:4]} * {13'd0, RECIP_25};
      qy_prod = {13'd0, uy_in[16:4]} * {13'd0, RECIP_25};
      mp_in   = early ? month_in + 4'd9 : month_in - 4'd3;
   end

   always_ff @(posedge clock) begin
      s1_u_ff     <= u_in;
      s1_uy_ff    <= uy_in;
      s1_q_ff     <= q_prod[24:17];
      s1_qy_ff    <= qy_prod[24:17];
      s1_mp_ff    <= mp_in;
      s1_month_ff <= month_in;
      s1_day_ff   <= day_in;
   end

   // stage 2
   logic [16:0] q400;
   logic [16:0] qy400;
   logic [16:0] yoe_diff;
   logic [16:0] ry_diff;
   logic [8:0]  ry;
   logic        leap_in;
   logic        valid_in;
   logic [24:0] era_in;

   logic [8:0]  s2_yoe_ff;
   logic [24:0] s2_era_ff;
   logic [3:0]  s2_mp_ff;
   logic [4:0]  s2_day_ff;
   logic        s2_leap_ff, s2_valid_ff;

   always_comb begin
      q400     = {1'b0, s1_q_ff, 8'd0} + {2'b0, s1_q_ff, 7'd0} + {5'd0, s1_q_ff, 4'd0};
      qy400    = {1'b0, s1_qy_ff, 8'd0} + {2'b0, s1_qy_ff, 7'd0} + {5'd0, s1_qy_ff, 4'd0};
      yoe_diff = s1_u_ff - q400;
      ry_diff  = s1_uy_ff - qy400;
      ry       = ry_diff[8:0];
      leap_in  = (ry == 9'd0) ||
                 ((ry[1:0] == 2'd0) && (ry != 9'd100) && (ry != 9'd200) && (ry != 9'd300));
      valid_in = (s1_month_ff >= 4'd1) && (s1_month_ff <= 4'd12) && (s1_day_ff != 5'd0) &&
                 (s1_day_ff <= month_days(s1_month_ff, leap_in));
      era_in   = {17'd0, s1_q_ff} * {7'd0, ERA_DAYS};
   end

   always_ff @(posedge clock) begin
      s2_yoe_ff   <= yoe_diff[8:0];
      s2_era_ff   <= era_in;
      s2_mp_ff    <= s1_mp_ff;
      s2_day_ff   <= s1_day_ff;
      s2_leap_ff  <= leap_in;
      s2_valid_ff <= valid_in;
   end

   // stage 3
   logic [17:0] yoe365;
   logic [18:0] doe_in;

   logic [18:0] s3_doe_ff;
   logic [24:0] s3_era_ff;
   logic        s3_leap_ff, s3_valid_ff;

   always_comb begin
      yoe365 = {1'b0, s2_yoe_ff, 8'd0} + {3'd0, s2_yoe_ff, 6'd0} + {4'd0, s2_yoe_ff, 5'd0} +
               {6'd0, s2_yoe_ff, 3'd0} + {7'd0, s2_yoe_ff, 2'd0} + {9'd0, s2_yoe_ff};
      doe_in = {1'b0, yoe365} + {12'd0, s2_yoe_ff[8:2]} - {17'd0, hundreds(s2_yoe_ff)} +
               {10'd0, month_start(s2_mp_ff)} + {14'd0, s2_day_ff} - 19'd1;
   end

   always_ff @(posedge clock) begin
      s3_doe_ff   <= doe_in;
      s3_era_ff   <= s2_era_ff;
      s3_leap_ff  <= s2_leap_ff;
      s3_valid_ff <= s2_valid_ff;
   end

   // stage 4
   logic [26:0] days_sum;

   logic [25:0] s4_days_ff;
   logic        s4_leap_ff, s4_valid_ff;

   always_comb begin
      days_sum = {2'b00, s3_era_ff} + {{8{s3_doe_ff[18]}}, s3_doe_ff} - EPOCH_BIAS;
   end

   always_ff @(posedge clock) begin
      s4_days_ff  <= days_sum[25:0];
      s4_leap_ff  <= s3_leap_ff;
      s4_valid_ff <= s3_valid_ff;
   end

   // stage 5, aligns with the day to civil path
   logic [25:0] s5_days_ff;
   logic        s5_leap_ff, s5_valid_ff;

   always_ff @(posedge clock) begin
      s5_days_ff  <= s4_days_ff;
      s5_leap_ff  <= s4_leap_ff;
      s5_valid_ff <= s4_valid_ff;
   end

   assign days     = s5_days_ff;
   assign is_leap  = s5_leap_ff;
   assign is_valid = s5_valid_ff;

endmodule

/* hdl/cdu_to_civil.sv */
// day number to civil date and iso weekday pipeline
module cdu_to_civil import cdu_pkg::*; (
   input  logic               clock,
   input  logic signed [24:0] days_a,
   output civil_type          civil
);

   localparam logic [26:0] ZP_BIAS    = 27'd16790138;
   localparam logic [26:0] WD_BIAS    = 27'd16777225;
   localparam logic [26:0] RECIP_ERA  = 27'd120414424;
   localparam logic [26:0] RECIP_7    = 27'd76695845;
   localparam logic [15:0] RECIP_365  = 16'd45965;
   localparam logic [17:0] LAST_DOE   = 18'd146096;
   localparam logic [18:0] YEAR_SHIFT = 19'd44000;

   // stage 1
   logic [26:0] w_sum;
   logic [26:0] v_sum;
   logic [52:0] era_prod;
   logic [52:0] wd_prod;

   logic [25:0] s1_w_ff, s1_v_ff;
   logic [7:0]  s1_era_ff;
   logic [22:0] s1_q7_ff;

   always_comb begin
      w_sum    = {{2{days_a[24]}}, days_a} + ZP_BIAS;
      v_sum    = {{2{days_a[24]}}, days_a} + WD_BIAS;
      era_prod = {27'd0, w_sum[25:0]} * {26'd0, RECIP_ERA};
      wd_prod  = {27'd0, v_sum[25:0]} * {26'd0, RECIP_7};
   end

   always_ff @(posedge clock) begin
      s1_w_ff   <= w_sum[25:0];
      s1_v_ff   <= v_sum[25:0];
      s1_era_ff <= era_prod[51:44];
      s1_q7_ff  <= wd_prod[51:29];
   end

   // stage 2
   logic [25:0] era_days;
   logic [25:0] doe_diff;
   logic [25:0] wd_diff;

   logic [17:0] s2_doe_ff;
   logic [7:0]  s2_era_ff;
   logic [2:0]  s2_wd_ff;

   always_comb begin
      era_days = {18'd0, s1_era_ff} * {8'd0, ERA_DAYS};
      doe_diff = s1_w_ff - era_days;
      wd_diff  = s1_v_ff - ({s1_q7_ff, 3'd0} - {3'd0, s1_q7_ff});
   end

   always_ff @(posedge clock) begin
      s2_doe_ff <= doe_diff[17:0];
      s2_era_ff <= s1_era_ff;
      s2_wd_ff  <= wd_diff[2:0] + 3'd1;
   end

   // stage 3
   logic [31:0] c1_prod;
   logic [2:0]  c2;
   logic [17:0] t_in;

   logic [17:0] s3_t_ff, s3_doe_ff;
   logic [7:0]  s3_era_ff;
   logic [2:0]  s3_wd_ff;

   always_comb begin
      c1_prod = {16'd0, s2_doe_ff[17:2]} * {16'd0, RECIP_365};
      c2      = 3'(s2_doe_ff >= 18'd36524) + 3'(s2_doe_ff >= 18'd73048) +
                3'(s2_doe_ff >= 18'd109572) + 3'(s2_doe_ff >= LAST_DOE);
      t_in    = s2_doe_ff - {11'd0, c1_prod[30:24]} + {15'd0, c2} -
                {17'd0, (s2_doe_ff == LAST_DOE)};
   end

   always_ff @(posedge clock) begin
      s3_t_ff   <= t_in;
      s3_doe_ff <= s2_doe_ff;
      s3_era_ff <= s2_era_ff;
      s3_wd_ff  <= s2_wd_ff;
   end

   // stage 4
   logic [33:0] yoe_prod;

   logic [8:0]  s4_yoe_ff;
   logic [17:0] s4_doe_ff;
   logic [7:0]  s4_era_ff;
   logic [2:0]  s4_wd_ff;

   always_comb begin
      yoe_prod = {16'd0, s3_t_ff} * {18'd0, RECIP_365};
   end

   always_ff @(posedge clock) begin
      s4_yoe_ff <= yoe_prod[32:24];
      s4_doe_ff <= s3_doe_ff;
      s4_era_ff <= s3_era_ff;
      s4_wd_ff  <= s3_wd_ff;
   end

   // stage 5
   logic [17:0] yoe365;
   logic [17:0] doy_diff;

   logic [8:0] s5_doy_ff, s5_yoe_ff;
   logic [7:0] s5_era_ff;
   logic [2:0] s5_wd_ff;

   always_comb begin
      yoe365   = {1'b0, s4_yoe_ff, 8'd0} + {3'd0, s4_yoe_ff, 6'd0} + {4'd0, s4_yoe_ff, 5'd0} +
                 {6'd0, s4_yoe_ff, 3'd0} + {7'd0, s4_yoe_ff, 2'd0} + {9'd0, s4_yoe_ff};
      doy_diff = s4_doe_ff - (yoe365 + {11'd0, s4_yoe_ff[8:2]} - {16'd0, hundreds(s4_yoe_ff)});
   end

   always_ff @(posedge clock) begin
      s5_doy_ff <= doy_diff[8:0];
      s5_yoe_ff <= s4_yoe_ff;
      s5_era_ff <= s4_era_ff;
      s5_wd_ff  <= s4_wd_ff;
   end

   // month split and year assembly
   logic [3:0]  mp;
   logic [8:0]  day_diff;
   logic [18:0] year_sum;

   always_comb begin
      mp = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (s5_doy_ff >= month_start(4'(k))) begin
            mp = 4'(k);
         end
      end
      day_diff = s5_doy_ff - month_start(mp) + 9'd1;
      year_sum = {10'd0, s5_yoe_ff} + {2'd0, s5_era_ff, 9'd0} - {4'd0, s5_era_ff, 7'd0} +
                 {7'd0, s5_era_ff, 4'd0} - YEAR_SHIFT + {18'd0, (mp >= 4'd10)};
      civil.year    = year_sum[16:0];
      civil.month   = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
      civil.day     = day_diff[4:0];
      civil.weekday = s5_wd_ff;
   end

endmodule

/* hdl/civil_date_day_number_unit.sv */
// top level of the civil date and day number unit
//
// command channel: an item is taken at a rising edge with start high and
// busy low. busy is high only while reset is held, so after reset an item
// can be taken every cycle.
// req_action selects the work: civil date to day number, day number to
// civil date and iso weekday, day number plus offset, or difference and
// compare of two day numbers.
// result channel: rsp_strobe is high for one cycle while the rsp_ ports
// carry the item's result; fields that the action does not produce read
// zero. results leave in the order the items came in.
// path: an accepted item passes the input register, five stages of the day to
// civil path (era reciprocal multiply, era remainder, century correction, year
// reciprocal multiply, day of year) and the result register before the strobe
// rises. throughput is one item per cycle.
// reset clears the stage valid bits and the strobe, so items in flight are
// dropped. the receiver cannot stall the channel.
module civil_date_day_number_unit import cdu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_year_in,
   input  logic [3:0]         req_month_in,
   input  logic [4:0]         req_day_in,
   input  logic signed [24:0] req_days_a,
   input  logic signed [24:0] req_days_b,
   output logic               rsp_strobe,
   output logic signed [25:0] rsp_result_days,
   output logic signed [16:0] rsp_year_out,
   output logic [3:0]         rsp_month_out,
   output logic [4:0]         rsp_day_out,
   output logic [2:0]         rsp_weekday,
   output logic               rsp_is_leap,
   output logic               rsp_is_valid,
   output logic               rsp_is_less,
   output logic               rsp_is_less_equal,
   output logic               rsp_is_equal
);

   logic accept;

   assign busy   = reset;
   assign accept = start && !busy;

   // input register and side delay line
   logic [PIPE_DEPTH:0]  vld_ff;
   action_type           act_ff   [PIPE_DEPTH+1];
   logic signed [24:0]   a_ff     [PIPE_DEPTH+1];
   logic signed [24:0]   b_ff     [PIPE_DEPTH+1];
   logic signed [15:0]   year_ff;
   logic [3:0]           month_ff;
   logic [4:0]           day_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-1:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff[0] <= action_type'(req_action);
         a_ff[0]   <= req_days_a;
         b_ff[0]   <= req_days_b;
         year_ff   <= req_year_in;
         month_ff  <= req_month_in;
         day_ff    <= req_day_in;
      end
      for (int i = 1; i <= PIPE_DEPTH; i++) begin
         act_ff[i] <= act_ff[i-1];
         a_ff[i]   <= a_ff[i-1];
         b_ff[i]   <= b_ff[i-1];
      end
   end

   // conversion paths
   logic signed [25:0] conv_days;
   logic               conv_leap;
   logic               conv_valid;
   civil_type          civil;

   cdu_to_days u_to_days (
      .clock    (clock),
      .year_in  (year_ff),
      .month_in (month_ff),
      .day_in   (day_ff),
      .days     (conv_days),
      .is_leap  (conv_leap),
      .is_valid (conv_valid)
   );

   cdu_to_civil u_to_civil (
      .clock  (clock),
      .days_a (a_ff[0]),
      .civil  (civil)
   );

   // result select
   logic signed [25:0] a_wide, b_wide;
   logic signed [25:0] days_in;
   logic signed [16:0] year_in;
   logic [3:0]         month_in;
   logic [4:0]         day_in;
   logic [2:0]         weekday_in;
   logic               leap_in, valid_in, less_in, less_equal_in, equal_in;

   always_comb begin
      a_wide        = {a_ff[PIPE_DEPTH][24], a_ff[PIPE_DEPTH]};
      b_wide        = {b_ff[PIPE_DEPTH][24], b_ff[PIPE_DEPTH]};
      days_in       = '0;
      year_in       = '0;
      month_in      = '0;
      day_in        = '0;
      weekday_in    = '0;
      leap_in       = 1'b0;
      valid_in      = 1'b0;
      less_in       = 1'b0;
      less_equal_in = 1'b0;
      equal_in      = 1'b0;
      case (act_ff[PIPE_DEPTH])
         ACT_TO_DAYS: begin
            days_in  = conv_days;
            leap_in  = conv_leap;
            valid_in = conv_valid;
         end
         ACT_TO_CIVIL: begin
            year_in    = civil.year;
            month_in   = civil.month;
            day_in     = civil.day;
            weekday_in = civil.weekday;
         end
         ACT_ADD: begin
            days_in = a_wide + b_wide;
         end
         ACT_DIFF: begin
            days_in       = a_wide - b_wide;
            less_in       = a_wide < b_wide;
            less_equal_in = a_wide <= b_wide;
            equal_in      = a_wide == b_wide;
         end
         default: begin
            days_in = '0;
         end
      endcase
   end

   // result register
   logic               rsp_strobe_ff;
   logic signed [25:0] rsp_result_days_ff;
   logic signed [16:0] rsp_year_out_ff;
   logic [3:0]         rsp_month_out_ff;
   logic [4:0]         rsp_day_out_ff;
   logic [2:0]         rsp_weekday_ff;
   logic               rsp_is_leap_ff, rsp_is_valid_ff;
   logic               rsp_is_less_ff, rsp_is_less_equal_ff, rsp_is_equal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vld_ff[PIPE_DEPTH];
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_days_ff   <= days_in;
      rsp_year_out_ff      <= year_in;
      rsp_month_out_ff     <= month_in;
      rsp_day_out_ff       <= day_in;
      rsp_weekday_ff       <= weekday_in;
      rsp_is_leap_ff       <= leap_in;
      rsp_is_valid_ff      <= valid_in;
      rsp_is_less_ff       <= less_in;
      rsp_is_less_equal_ff <= less_equal_in;
      rsp_is_equal_ff      <= equal_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_result_days   = rsp_result_days_ff;
   assign rsp_year_out      = rsp_year_out_ff;
   assign rsp_month_out     = rsp_month_out_ff;
   assign rsp_day_out       = rsp_day_out_ff;
   assign rsp_weekday       = rsp_weekday_ff;
   assign rsp_is_leap       = rsp_is_leap_ff;
   assign rsp_is_valid      = rsp_is_valid_ff;
   assign rsp_is_less       = rsp_is_less_ff;
   assign rsp_is_less_equal = rsp_is_less_equal_ff;
   assign rsp_is_equal      = rsp_is_equal_ff;

endmodule
